@@ src/aps_pkg.sv @@
// Shared types and constants for the aging priority scheduler.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package aps_pkg;

    // Table geometry
    localparam int SLOTS  = 16;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Field widths fixed by the beat format
    localparam int SLOT_W  = 4;
    localparam int TIME_W  = 16;
    localparam int WORK_W  = 16;
    localparam int AGE_W   = 32;
    localparam int INC_W   = 2;

    // Aging increments
    localparam logic [INC_W-1:0] AGE_RUN    = INC_W'(1);
    localparam logic [INC_W-1:0] AGE_OTHERS = INC_W'(2);

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    // Input beat
    typedef struct packed {
        t_cmd              cmd;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] arrival;
        logic [WORK_W-1:0] burst;
    } t_sched_in;

    // Result beat
    typedef struct packed {
        logic              ran_valid;
        logic [SLOT_W-1:0] ran_slot;
        logic              finished;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] waiting_time;
        logic              all_done;
        logic              load_error;
    } t_sched_out;

    // One job table entry
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [WORK_W-1:0] burst;
        logic [WORK_W-1:0] remaining;
        logic [AGE_W-1:0]  age;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    // Sequencer controls toward the datapath
    typedef struct packed {
        logic             busy;
        logic             load_go;
        logic             tick_go;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             proc_en;
        logic [IDX_W-1:0] proc_idx;
        logic             fin;
    } t_ctl;

endpackage

`default_nettype wire

@@ src/aps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module aps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/aps_age_unit.sv @@
// Shared saturating aging adder and age comparator.
// Depends on aps_pkg for widths.
`default_nettype none

module aps_age_unit (
    input  wire logic [aps_pkg::AGE_W-1:0] i_age,
    input  wire logic [aps_pkg::INC_W-1:0] i_inc,
    input  wire logic [aps_pkg::AGE_W-1:0] i_ref,
    output logic      [aps_pkg::AGE_W-1:0] o_sum,
    output logic                           o_gt
);

    logic [aps_pkg::AGE_W:0] w_wide;

    // Add with saturation at all ones
    always_comb begin
        w_wide = {1'b0, i_age} + (aps_pkg::AGE_W + 1)'(i_inc);
        o_sum  = w_wide[aps_pkg::AGE_W] ? '1 : w_wide[aps_pkg::AGE_W-1:0];
    end

    // Strictly greater keeps the lowest slot on ties
    assign o_gt = (i_age > i_ref);

endmodule

`default_nettype wire

@@ src/aps_ctrl.sv @@
// Sequencer: accepts commands and walks the slot table once per tick.
// Depends on aps_pkg for states, commands and the control struct.
`default_nettype none

module aps_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire aps_pkg::t_cmd i_cmd,
    output aps_pkg::t_ctl     o_ctl
);

    aps_pkg::t_state           r_state, n_state;
    logic [aps_pkg::CNT_W-1:0] r_idx, n_idx;
    logic [aps_pkg::CNT_W-1:0] w_prev;
    logic                      w_accept;
    logic                      w_last;

    assign w_accept = i_start && (r_state == aps_pkg::ST_IDLE);
    assign w_last   = (r_idx == aps_pkg::CNT_W'(aps_pkg::SLOTS));
    assign w_prev   = r_idx - aps_pkg::CNT_W'(1);

    // Next state and slot counter
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            aps_pkg::ST_IDLE: begin
                n_idx = '0;
                if (w_accept && (i_cmd == aps_pkg::CMD_TICK)) begin
                    n_state = aps_pkg::ST_SCAN;
                end
            end
            aps_pkg::ST_SCAN: begin
                n_idx = r_idx + aps_pkg::CNT_W'(1);
                if (w_last) begin
                    n_state = aps_pkg::ST_FIN;
                end
            end
            aps_pkg::ST_FIN: begin
                n_state = aps_pkg::ST_IDLE;
            end
            default: begin
                n_state = aps_pkg::ST_IDLE;
            end
        endcase
    end

    // Controls per state
    always_comb begin
        o_ctl          = '0;
        o_ctl.rd_addr  = r_idx[aps_pkg::IDX_W-1:0];
        o_ctl.proc_idx = w_prev[aps_pkg::IDX_W-1:0];
        case (r_state)
            aps_pkg::ST_IDLE: begin
                o_ctl.load_go = w_accept && (i_cmd == aps_pkg::CMD_LOAD);
                o_ctl.tick_go = w_accept && (i_cmd == aps_pkg::CMD_TICK);
            end
            aps_pkg::ST_SCAN: begin
                o_ctl.busy    = 1'b1;
                o_ctl.rd_en   = !w_last;
                o_ctl.proc_en = (r_idx != '0);
            end
            aps_pkg::ST_FIN: begin
                o_ctl.busy = 1'b1;
                o_ctl.fin  = 1'b1;
            end
            default: begin
                o_ctl.busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aps_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Scan never reads past the table and finishes on the last slot
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aps_pkg::ST_SCAN) |-> (r_idx <= aps_pkg::CNT_W'(aps_pkg::SLOTS)))
        else $error("slot counter ran past the table");

    a_fin_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aps_pkg::ST_FIN) |-> ($past(r_state) == aps_pkg::ST_SCAN))
        else $error("finish step not preceded by a scan");

    a_tick_enters_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.tick_go |=> (r_state == aps_pkg::ST_SCAN) && (r_idx == '0))
        else $error("tick command did not start a scan at slot zero");

endmodule

`default_nettype wire

@@ src/aging_priority_scheduler.sv @@
// Top level of the aging priority scheduler: job table RAM, shared aging unit,
// sequencer and the per-tick selection datapath. Depends on aps_pkg and all submodules.
//
//  channel  | ports                        | handshake
//  ---------+------------------------------+-----------------------------------
//  command  | start, busy, i_in            | beat taken when start && !busy
//  result   | o_valid, o_out               | one-cycle strobe, cannot be held
//
// A load is taken while the block is idle; its result shows in the next cycle and the
// block is ready again at once. A tick reads one slot per cycle from the
// job RAM through the scan state, then takes a finish step; busy is high
// through both. The result strobe follows the finish step. Reset is synchronous,
// active low, and clears the loaded and active bits and time; table entries need no clearing.
`default_nettype none

module aging_priority_scheduler (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire aps_pkg::t_sched_in i_in,
    output logic                busy,
    output logic                o_valid,
    output aps_pkg::t_sched_out o_out
);

    aps_pkg::t_ctl  w_ctl;
    aps_pkg::t_job  w_rd_job;
    aps_pkg::t_job  w_wr_job;
    logic [aps_pkg::JOB_W-1:0] w_rd_data;
    logic           w_we;
    logic [aps_pkg::IDX_W-1:0] w_waddr;

    logic [aps_pkg::AGE_W-1:0] w_add_a;
    logic [aps_pkg::INC_W-1:0] w_add_inc;
    logic [aps_pkg::AGE_W-1:0] w_sum;
    logic                      w_gt;

    logic [aps_pkg::SLOTS-1:0] r_loaded, n_loaded;
    logic [aps_pkg::SLOTS-1:0] r_active, n_active;
    logic [aps_pkg::TIME_W-1:0] r_now, n_now;
    logic                      r_found, n_found;
    logic [aps_pkg::IDX_W-1:0] r_best_idx, n_best_idx;
    aps_pkg::t_job             r_best, n_best;
    logic                      r_out_vld, n_out_vld;
    aps_pkg::t_sched_out       r_out, n_out;

    logic                      w_load_ok;
    logic [aps_pkg::IDX_W-1:0] w_load_idx;
    logic                      w_elig;
    logic                      w_take;
    logic                      w_last_unit;
    logic [aps_pkg::TIME_W-1:0] w_ct;
    logic [aps_pkg::TIME_W:0]   w_used;
    logic [aps_pkg::TIME_W-1:0] w_wait;

    aps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_in.cmd),
        .o_ctl   (w_ctl)
    );

    aps_ram #(
        .WIDTH (aps_pkg::JOB_W),
        .DEPTH (aps_pkg::SLOTS)
    ) u_job_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr_job),
        .i_re    (w_ctl.rd_en),
        .i_raddr (w_ctl.rd_addr),
        .o_rdata (w_rd_data)
    );

    assign w_rd_job = aps_pkg::t_job'(w_rd_data);

    // Share the adder: +2 for scanned slots, +1 for the winner at finish
    assign w_add_a   = w_ctl.fin ? r_best.age : w_rd_job.age;
    assign w_add_inc = w_ctl.fin ? aps_pkg::AGE_RUN : aps_pkg::AGE_OTHERS;

    aps_age_unit u_age (
        .i_age (w_add_a),
        .i_inc (w_add_inc),
        .i_ref (r_best.age),
        .o_sum (w_sum),
        .o_gt  (w_gt)
    );

    // Load decode
    assign w_load_ok  = w_ctl.load_go && (i_in.burst != '0)
                        && (32'(i_in.slot) < aps_pkg::SLOTS);
    assign w_load_idx = aps_pkg::IDX_W'(i_in.slot);

    // Scan decode on the slot whose read data is back
    assign w_elig = w_ctl.proc_en && r_loaded[w_ctl.proc_idx]
                    && (w_rd_job.arrival <= r_now);
    assign w_take = w_elig && r_active[w_ctl.proc_idx] && (!r_found || w_gt);

    // Finish arithmetic
    assign w_last_unit = (r_best.remaining == aps_pkg::WORK_W'(1));
    assign w_ct        = (r_now == aps_pkg::TIME_MAX) ? aps_pkg::TIME_MAX
                                                      : r_now + aps_pkg::TIME_W'(1);
    assign w_used      = {1'b0, r_best.arrival} + (aps_pkg::TIME_W + 1)'(r_best.burst);
    assign w_wait      = ({1'b0, w_ct} > w_used)
                         ? w_ct - w_used[aps_pkg::TIME_W-1:0] : '0;

    // Table write port
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = w_ctl.proc_idx;
        w_wr_job = w_rd_job;
        if (w_ctl.load_go) begin
            w_we               = w_load_ok;
            w_waddr            = w_load_idx;
            w_wr_job.arrival   = i_in.arrival;
            w_wr_job.burst     = i_in.burst;
            w_wr_job.remaining = i_in.burst;
            w_wr_job.age       = '0;
        end else if (w_ctl.fin) begin
            w_we               = r_found;
            w_waddr            = r_best_idx;
            w_wr_job           = r_best;
            w_wr_job.remaining = r_best.remaining - aps_pkg::WORK_W'(1);
            w_wr_job.age       = w_sum;
        end else begin
            w_we         = w_elig;
            w_wr_job.age = w_sum;
        end
    end

    // Selection, flags, time and the result beat
    always_comb begin
        n_loaded   = r_loaded;
        n_active   = r_active;
        n_now      = r_now;
        n_found    = r_found;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_out_vld  = 1'b0;
        n_out      = r_out;

        if (w_ctl.tick_go) begin
            n_found = 1'b0;
        end

        if (w_take) begin
            n_found    = 1'b1;
            n_best_idx = w_ctl.proc_idx;
            n_best     = w_rd_job;
        end

        if (w_load_ok) begin
            n_loaded[w_load_idx] = 1'b1;
            n_active[w_load_idx] = 1'b1;
        end

        if (w_ctl.fin && r_found && w_last_unit) begin
            n_active[r_best_idx] = 1'b0;
        end

        if (w_ctl.load_go) begin
            n_out_vld        = 1'b1;
            n_out            = '0;
            n_out.all_done   = ~|n_active;
            n_out.load_error = (i_in.burst == '0);
        end else if (w_ctl.fin) begin
            n_out_vld       = 1'b1;
            n_out           = '0;
            n_out.ran_valid = r_found;
            n_out.ran_slot  = r_found ? aps_pkg::SLOT_W'(r_best_idx) : '0;
            n_out.finished  = r_found && w_last_unit;
            if (r_found && w_last_unit) begin
                n_out.completion_time = w_ct;
                n_out.waiting_time    = w_wait;
            end
            n_out.all_done = ~|n_active;
            n_now          = w_ct;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded  <= '0;
            r_active  <= '0;
            r_now     <= '0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_loaded  <= n_loaded;
            r_active  <= n_active;
            r_now     <= n_now;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload holds
    always_ff @(posedge i_clk) begin
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_out      <= n_out;
    end

    assign busy    = w_ctl.busy;
    assign o_valid = r_out_vld;
    assign o_out   = r_out;

    a_result_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat shown while a tick is still in work");

    a_finish_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.finished) |-> (o_out.ran_valid && (o_out.completion_time != '0)))
        else $error("finished job reported without a run");

    a_all_done_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.all_done == (r_active == '0)))
        else $error("all_done disagrees with the active slot flags");

    a_active_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_active & ~r_loaded) == '0))
        else $error("active flag set on an unloaded slot");

    a_tick_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_in.cmd == aps_pkg::CMD_TICK)) |=> busy)
        else $error("tick beat taken without going busy");

endmodule

`default_nettype wire

@@ tb/sv/aging_priority_scheduler_test.sv @@
// Self-checking bench for the aging priority scheduler: drives load and tick beats,
// predicts result beats in its own scheduler model or takes a fixed one, and compares field by field.
// Depends on aps_pkg and the aging_priority_scheduler top level.
`default_nettype none

module aging_priority_scheduler_test;

    // One row of the directed stimulus; want is used only when fixed is set
    typedef struct {
        aps_pkg::t_sched_in  beat;
        bit                  fixed;
        aps_pkg::t_sched_out want;
    } t_row;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    aps_pkg::t_sched_in  i_in    = '0;
    logic                busy;
    logic                o_valid;
    aps_pkg::t_sched_out o_out;

    // Scheduler model state
    logic [aps_pkg::TIME_W-1:0] sched_arrival [aps_pkg::SLOTS];
    logic [aps_pkg::WORK_W-1:0] sched_left    [aps_pkg::SLOTS];
    logic [aps_pkg::WORK_W-1:0] sched_len     [aps_pkg::SLOTS];
    logic [aps_pkg::AGE_W-1:0]  sched_age     [aps_pkg::SLOTS];
    bit                         sched_loaded  [aps_pkg::SLOTS];
    logic [aps_pkg::TIME_W-1:0] sched_now = '0;

    aps_pkg::t_sched_out pending_results [$];
    t_row                directed_rows   [$];

    int idle_pct       = 0;
    int beats_sent     = 0;
    int work_beats     = 0;
    int tick_beats     = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int jobs_finished  = 0;
    int loads_rejected = 0;
    int done_seen      = 0;

    aging_priority_scheduler u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_in    (i_in),
        .busy    (busy),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    always #6 i_clk = ~i_clk;

    // Add with saturation at the top of the aging range
    function automatic logic [aps_pkg::AGE_W-1:0] age_plus(logic [aps_pkg::AGE_W-1:0] a,
                                                           int unsigned d);
        logic [aps_pkg::AGE_W:0] s;
        s = {1'b0, a} + d;
        return s[aps_pkg::AGE_W] ? '1 : s[aps_pkg::AGE_W-1:0];
    endfunction

    // Apply one beat to the model and return the result beat it causes
    function automatic aps_pkg::t_sched_out schedule_step(aps_pkg::t_sched_in beat);
        aps_pkg::t_sched_out        res;
        logic [aps_pkg::TIME_W-1:0] t;
        int                         i;
        int                         best;
        bit                         found;
        int                         ct;
        int                         used;
        res = '0;
        if (beat.cmd == aps_pkg::CMD_LOAD) begin
            if (beat.burst == '0) begin
                res.load_error = 1'b1;
            end else begin
                sched_arrival[beat.slot] = beat.arrival;
                sched_len[beat.slot]     = beat.burst;
                sched_left[beat.slot]    = beat.burst;
                sched_age[beat.slot]     = '0;
                sched_loaded[beat.slot]  = 1'b1;
            end
        end else begin
            t     = sched_now;
            best  = 0;
            found = 1'b0;
            // pick the oldest-aged eligible job with work left, lowest slot on ties
            for (i = 0; i < aps_pkg::SLOTS; i++) begin
                if (sched_loaded[i] && sched_arrival[i] <= t && sched_left[i] != '0) begin
                    if (!found || sched_age[i] > sched_age[best]) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            // age every other arrived job, finished ones too
            for (i = 0; i < aps_pkg::SLOTS; i++) begin
                if (sched_loaded[i] && sched_arrival[i] <= t && !(found && i == best)) begin
                    sched_age[i] = age_plus(sched_age[i], aps_pkg::AGE_OTHERS);
                end
            end
            if (found) begin
                res.ran_valid   = 1'b1;
                res.ran_slot    = aps_pkg::SLOT_W'(best);
                sched_left[best] = sched_left[best] - 1'b1;
                sched_age[best]  = age_plus(sched_age[best], aps_pkg::AGE_RUN);
                if (sched_left[best] == '0) begin
                    ct   = (t == aps_pkg::TIME_MAX) ? int'(aps_pkg::TIME_MAX) : int'(t) + 1;
                    used = int'(sched_arrival[best]) + int'(sched_len[best]);
                    res.finished        = 1'b1;
                    res.completion_time = aps_pkg::TIME_W'(ct);
                    res.waiting_time    = (ct > used) ? aps_pkg::TIME_W'(ct - used) : '0;
                end
            end
            sched_now = (t == aps_pkg::TIME_MAX) ? aps_pkg::TIME_MAX : t + 1'b1;
        end
        // all done reflects the table after this beat
        res.all_done = 1'b1;
        for (i = 0; i < aps_pkg::SLOTS; i++) begin
            if (sched_loaded[i] && sched_left[i] != '0) res.all_done = 1'b0;
        end
        return res;
    endfunction

    function automatic aps_pkg::t_sched_out mk_out(bit rv, int rs, bit fin, int ct, int wt,
                                                   bit ad, bit le);
        aps_pkg::t_sched_out r;
        r.ran_valid       = rv;
        r.ran_slot        = aps_pkg::SLOT_W'(rs);
        r.finished        = fin;
        r.completion_time = aps_pkg::TIME_W'(ct);
        r.waiting_time    = aps_pkg::TIME_W'(wt);
        r.all_done        = ad;
        r.load_error      = le;
        return r;
    endfunction

    function automatic aps_pkg::t_sched_in load_beat(int s, int a, int b);
        aps_pkg::t_sched_in r;
        r.cmd     = aps_pkg::CMD_LOAD;
        r.slot    = aps_pkg::SLOT_W'(s);
        r.arrival = aps_pkg::TIME_W'(a);
        r.burst   = aps_pkg::WORK_W'(b);
        return r;
    endfunction

    // Tick beat with junk in the fields the block ignores
    function automatic aps_pkg::t_sched_in tick_beat();
        aps_pkg::t_sched_in r;
        r.cmd     = aps_pkg::CMD_TICK;
        r.slot    = aps_pkg::SLOT_W'($urandom_range(0, aps_pkg::SLOTS - 1));
        r.arrival = aps_pkg::TIME_W'($urandom);
        r.burst   = aps_pkg::WORK_W'($urandom);
        return r;
    endfunction

    task automatic add_row(aps_pkg::t_sched_in beat, bit fixed, aps_pkg::t_sched_out want);
        t_row r;
        r.beat  = beat;
        r.fixed = fixed;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    // Present one beat from a falling edge, hold it until taken, log its result
    task automatic send_beat(aps_pkg::t_sched_in beat, bit fixed, aps_pkg::t_sched_out want);
        aps_pkg::t_sched_out pred;
        int                  gap;
        gap = 0;
        if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 24);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_in  <= beat;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pred = schedule_step(beat);
        pending_results.push_back(fixed ? want : pred);
        beats_sent++;
        if (beat.cmd == aps_pkg::CMD_TICK) tick_beats++;
        if (!(beat.cmd == aps_pkg::CMD_LOAD && beat.burst == '0)) work_beats++;
        @(negedge i_clk);
    endtask

    // Hold the sender until every result beat is back
    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    // One burst of work: one to six jobs arriving near now, stray rejected loads, then ticks
    task automatic run_episode();
        int n_jobs;
        int n_work;
        int n_ticks;
        int k;
        int s;
        int lb;
        n_jobs = $urandom_range(1, 6);
        n_work = 0;
        s      = $urandom_range(0, aps_pkg::SLOTS - 1);
        // sometimes park a full-range job in the slot of the first real job, which replaces it
        if ($urandom_range(0, 99) < 20) begin
            send_beat(load_beat(s, $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF)),
                      1'b0, '0);
            if ($urandom_range(0, 1) == 1) send_beat(tick_beat(), 1'b0, '0);
        end
        for (k = 0; k < n_jobs; k++) begin
            lb = $urandom_range(1, 5);
            send_beat(load_beat(s, int'(sched_now) + $urandom_range(0, 6), lb), 1'b0, '0);
            n_work += lb;
            if ($urandom_range(0, 99) < 15) begin
                send_beat(load_beat($urandom_range(0, aps_pkg::SLOTS - 1),
                                    $urandom_range(0, 16'hFFFF), 0), 1'b0, '0);
            end
            if ($urandom_range(0, 99) < 25) send_beat(tick_beat(), 1'b0, '0);
            s = $urandom_range(0, aps_pkg::SLOTS - 1);
        end
        n_ticks = $urandom_range(n_work / 2, n_work + 8);
        repeat (n_ticks) send_beat(tick_beat(), 1'b0, '0);
    endtask

    task automatic report_mismatch(string why, aps_pkg::t_sched_out want,
                                   aps_pkg::t_sched_out got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("MISMATCH %s at result %0d", why, results_seen);
            $display("  exp ran=%0b slot=%0d fin=%0b ct=%0d wt=%0d done=%0b err=%0b",
                     want.ran_valid, want.ran_slot, want.finished, want.completion_time,
                     want.waiting_time, want.all_done, want.load_error);
            $display("  got ran=%0b slot=%0d fin=%0b ct=%0d wt=%0d done=%0b err=%0b",
                     got.ran_valid, got.ran_slot, got.finished, got.completion_time,
                     got.waiting_time, got.all_done, got.load_error);
        end
    endtask

    // Check each result beat against the oldest prediction
    always @(posedge i_clk) begin : check_result
        aps_pkg::t_sched_out want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (o_out.finished === 1'b1) jobs_finished++;
            if (o_out.load_error === 1'b1) loads_rejected++;
            if (o_out.all_done === 1'b1) done_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", '0, o_out);
            end else begin
                want = pending_results.pop_front();
                if (o_out.ran_valid !== want.ran_valid || o_out.ran_slot !== want.ran_slot
                    || o_out.finished !== want.finished
                    || o_out.completion_time !== want.completion_time
                    || o_out.waiting_time !== want.waiting_time
                    || o_out.all_done !== want.all_done
                    || o_out.load_error !== want.load_error) begin
                    report_mismatch("field", want, o_out);
                end
            end
        end
    end

    // Hard stop well past the slowest correct run
    initial begin
        #60000000;
        $display("timeout with %0d result beats outstanding", pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int k;
        int phase;
        int wait_cycles;
        int directed_done;
        int idle_modes [3];
        idle_modes = '{0, 56, 38};

        // Directed rows: empty table, rejects, extremes, reload, ties, idle ticks
        add_row(tick_beat(), 1'b1, mk_out(0, 0, 0, 0, 0, 1, 0));
        add_row(load_beat(5, 0, 0), 1'b1, mk_out(0, 0, 0, 0, 0, 1, 1));
        add_row(load_beat(15, 16'hFFFF, 16'hFFFF), 1'b1, mk_out(0, 0, 0, 0, 0, 0, 0));
        add_row(tick_beat(), 1'b1, mk_out(0, 0, 0, 0, 0, 0, 0));
        add_row(load_beat(0, 0, 1), 1'b0, '0);
        add_row(tick_beat(), 1'b0, '0);
        add_row(load_beat(15, 16'hFFFF, 0), 1'b1, mk_out(0, 0, 0, 0, 0, 0, 1));
        add_row(load_beat(15, 2, 2), 1'b0, '0);
        add_row(load_beat(1, 3, 3), 1'b0, '0);
        add_row(load_beat(2, 3, 3), 1'b0, '0);
        repeat (11) add_row(tick_beat(), 1'b0, '0);

        // Hold reset, then release on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 0;
        foreach (directed_rows[k]) begin
            send_beat(directed_rows[k].beat, directed_rows[k].fixed, directed_rows[k].want);
        end
        directed_done = work_beats;

        // Random episodes across idle phases; drain once before the third phase
        phase = 0;
        while (work_beats - directed_done < 830) begin
            if ((work_beats - directed_done) / 225 != phase) begin
                phase = (work_beats - directed_done) / 225;
                if (phase == 2) drain_results();
                idle_pct = idle_modes[phase % 3];
            end
            run_episode();
        end

        // Clear the table, then park two jobs that arrive far in the future
        idle_pct = 0;
        for (k = 0; k < aps_pkg::SLOTS; k++) send_beat(load_beat(k, 0, 1), 1'b0, '0);
        repeat (aps_pkg::SLOTS) send_beat(tick_beat(), 1'b0, '0);
        send_beat(load_beat(3, 65533, 5), 1'b0, '0);
        send_beat(load_beat(9, 65535, 2), 1'b0, '0);
        repeat (12) send_beat(tick_beat(), 1'b0, '0);

        // Wait out the last results
        start <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 200) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (30) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d predicted result beats never arrived", pending_results.size());
            mismatch_count += pending_results.size();
        end

        $display("covered %0d beats (%0d ticks), %0d results, %0d jobs finished",
                 beats_sent, tick_beats, results_seen, jobs_finished);
        $display("  %0d rejected loads, %0d all-done beats", loads_rejected, done_seen);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
src/aps_pkg.sv
src/aps_ram.sv
src/aps_age_unit.sv
src/aps_ctrl.sv
src/aging_priority_scheduler.sv
tb/sv/aging_priority_scheduler_test.sv
